@@ sv/iee_pkg.sv @@
// Package for the infix expression evaluator: transaction structs,
// operator and status codes, character constants.
// No dependencies.
package iee_pkg;

  typedef struct packed {
    logic [7:0] character;
    logic       end_of_expression;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
  } out_item_t;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_OPEN = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_DIV0      = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [1:0] ST_MALFORMED = 2'd3;

  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_ADD   = 8'h2B;
  localparam logic [7:0] CH_SUB   = 8'h2D;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic        start;
    logic [2:0]  op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  function automatic logic [1:0] prec(input logic [2:0] op);
    logic [1:0] p;
    p = 2'd0;
    if (op == OP_MUL || op == OP_DIV) p = 2'd2;
    else if (op == OP_ADD || op == OP_SUB) p = 2'd1;
    return p;
  endfunction

endpackage

@@ sv/infix_expression_evaluator_unit.sv @@
// Infix expression evaluator, top level. Stacks live in two synchronous
// memories; a small sequencer reads the stack tops and drives iee_alu.
// Depends on iee_pkg and iee_alu.
//
// Usage: one ASCII character per input transaction on in_item, with
// end_of_expression set on the last one. A result transaction (value,
// status) appears on out_item only after the last character.
// A digit, '(' or any other character passes through decode and finish;
// an operator or ')' also compares against the operator-stack top. Each
// reduction reads the two value tops and runs iee_alu; / uses the restoring
// divider, which produces one quotient bit per cycle. After the last
// character the remaining operators are reduced before the result is
// registered. Stack tops are read through the memories' registered read ports.
// Reset clears counts, error and state; stack contents need no clearing.
// The result sits in an output register; the block takes the next
// character while a result waits on a stalled receiver, and stalls its
// input whenever it is not idle, including while a result waits for the register.
module infix_expression_evaluator_unit #(
  parameter int VALUE_DEPTH    = 16,
  parameter int OPERATOR_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  iee_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output iee_pkg::out_item_t out_item
);

  localparam int VW = $clog2(VALUE_DEPTH + 1);
  localparam int OW = $clog2(OPERATOR_DEPTH + 1);
  localparam int VA = (VALUE_DEPTH > 1) ? $clog2(VALUE_DEPTH) : 1;
  localparam int OA = (OPERATOR_DEPTH > 1) ? $clog2(OPERATOR_DEPTH) : 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_TOP  = 4'd2;
  localparam logic [3:0] S_RDV  = 4'd3;
  localparam logic [3:0] S_RDV2 = 4'd4;
  localparam logic [3:0] S_ALU  = 4'd5;
  localparam logic [3:0] S_FIN  = 4'd6;
  localparam logic [3:0] S_RES  = 4'd7;
  localparam logic [3:0] S_RES2 = 4'd8;

  logic [31:0] vmem [VALUE_DEPTH];
  logic [2:0]  omem [OPERATOR_DEPTH];

  logic [3:0]  state;
  logic [VW-1:0] vcount;
  logic [OW-1:0] ocount;
  logic [1:0]  err;
  logic [7:0]  ch;
  logic        last;
  logic        final_phase;
  logic [2:0]  newop;
  logic        close_mode;

  logic          v_we;
  logic [VA-1:0] v_waddr;
  logic [31:0]   v_wdata;
  logic [VA-1:0] v_raddr;
  logic [31:0]   v_rdata;
  logic          o_we;
  logic [OA-1:0] o_waddr;
  logic [2:0]    o_wdata;
  logic [OA-1:0] o_raddr;
  logic [2:0]    o_rdata;

  logic [2:0]  topop;
  logic [31:0] opb;

  iee_pkg::alu_req_t alu_req;
  logic              alu_done;
  logic [31:0]       alu_result;

  iee_alu u_alu (
    .clk(clk), .rst(rst), .req(alu_req), .done(alu_done), .result(alu_result)
  );

  always_ff @(posedge clk) begin
    if (v_we) vmem[v_waddr] <= v_wdata;
    v_rdata <= vmem[v_raddr];
  end

  always_ff @(posedge clk) begin
    if (o_we) omem[o_waddr] <= o_wdata;
    o_rdata <= omem[o_raddr];
  end

  assign in_stall = (state != S_IDLE);

  // Addresses and write strobes are combinational from the current state.
  always_comb begin
    v_we    = 1'b0;
    v_waddr = vcount[VA-1:0];
    v_wdata = {24'd0, ch - iee_pkg::CH_ZERO};
    v_raddr = vcount[VA-1:0] - VA'(1);
    o_we    = 1'b0;
    o_waddr = ocount[OA-1:0];
    o_wdata = newop;
    o_raddr = ocount[OA-1:0] - OA'(1);
    alu_req = '0;
    unique case (state)
      S_DEC: begin
        if (err == iee_pkg::ST_OK && ch >= iee_pkg::CH_ZERO && ch <= iee_pkg::CH_NINE &&
            vcount < VW'(VALUE_DEPTH))
          v_we = 1'b1;
        if (err == iee_pkg::ST_OK && ch == iee_pkg::CH_OPEN &&
            ocount < OW'(OPERATOR_DEPTH)) begin
          o_we    = 1'b1;
          o_wdata = iee_pkg::OP_OPEN;
        end
      end
      S_TOP: begin
        if (!final_phase && !close_mode && ocount < OW'(OPERATOR_DEPTH) &&
            (ocount == '0 || iee_pkg::prec(o_rdata) < iee_pkg::prec(newop)))
          o_we = 1'b1;
      end
      S_RDV: v_raddr = vcount[VA-1:0] - VA'(2);
      S_RDV2: begin
        alu_req.start = 1'b1;
        alu_req.op    = topop;
        alu_req.a     = v_rdata;
        alu_req.b     = opb;
      end
      S_ALU: begin
        v_waddr = vcount[VA-1:0] - VA'(2);
        v_wdata = alu_result;
        v_we    = alu_done;
        // The operator count drops at this edge, so fetch the entry below the top.
        if (alu_done) o_raddr = ocount[OA-1:0] - OA'(2);
      end
      S_RES: v_raddr = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      vcount      <= '0;
      ocount      <= '0;
      err         <= iee_pkg::ST_OK;
      out_valid   <= 1'b0;
      final_phase <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_RES2) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            ch          <= in_item.character;
            last        <= in_item.end_of_expression;
            final_phase <= 1'b0;
            state       <= S_DEC;
          end
        end
        S_DEC: begin
          // Top of operator stack is valid from the read issued in S_IDLE.
          if (err != iee_pkg::ST_OK) begin
            state <= S_FIN;
          end else if (ch >= iee_pkg::CH_ZERO && ch <= iee_pkg::CH_NINE) begin
            if (vcount >= VW'(VALUE_DEPTH)) err <= iee_pkg::ST_OVERFLOW;
            else begin
              vcount <= vcount + VW'(1);
            end
            state <= S_FIN;
          end else if (ch == iee_pkg::CH_OPEN) begin
            newop      <= iee_pkg::OP_OPEN;
            close_mode <= 1'b0;
            if (ocount >= OW'(OPERATOR_DEPTH)) err <= iee_pkg::ST_OVERFLOW;
            else ocount <= ocount + OW'(1);
            state <= S_FIN;
          end else if (ch == iee_pkg::CH_CLOSE) begin
            close_mode <= 1'b1;
            state      <= S_TOP;
          end else if (ch == iee_pkg::CH_ADD || ch == iee_pkg::CH_SUB ||
                       ch == iee_pkg::CH_MUL || ch == iee_pkg::CH_DIV) begin
            close_mode <= 1'b0;
            newop <= (ch == iee_pkg::CH_ADD) ? iee_pkg::OP_ADD :
                     (ch == iee_pkg::CH_SUB) ? iee_pkg::OP_SUB :
                     (ch == iee_pkg::CH_MUL) ? iee_pkg::OP_MUL : iee_pkg::OP_DIV;
            state <= S_TOP;
          end else begin
            err   <= iee_pkg::ST_MALFORMED;
            state <= S_FIN;
          end
        end
        S_TOP: begin
          // o_rdata holds the current top of the operator stack.
          topop <= o_rdata;
          if (final_phase) begin
            if (ocount == '0) state <= S_RES;
            else if (o_rdata == iee_pkg::OP_OPEN || vcount < VW'(2)) begin
              err <= iee_pkg::ST_MALFORMED; state <= S_RES;
            end else state <= S_RDV;
          end else if (close_mode) begin
            if (ocount == '0) begin
              err <= iee_pkg::ST_MALFORMED; state <= S_FIN;
            end else if (o_rdata == iee_pkg::OP_OPEN) begin
              ocount <= ocount - OW'(1); state <= S_FIN;
            end else if (vcount < VW'(2)) begin
              err <= iee_pkg::ST_MALFORMED; state <= S_FIN;
            end else state <= S_RDV;
          end else begin
            if (ocount == '0 || iee_pkg::prec(o_rdata) < iee_pkg::prec(newop)) begin
              if (ocount >= OW'(OPERATOR_DEPTH)) err <= iee_pkg::ST_OVERFLOW;
              else ocount <= ocount + OW'(1);
              state <= S_FIN;
            end else if (vcount < VW'(2)) begin
              err <= iee_pkg::ST_MALFORMED; state <= S_FIN;
            end else state <= S_RDV;
          end
        end
        S_RDV: begin
          opb   <= v_rdata;
          state <= S_RDV2;
        end
        S_RDV2: begin
          if (topop == iee_pkg::OP_DIV && opb == 32'd0) begin
            // The request issued this cycle computes garbage; it is dropped.
            err   <= iee_pkg::ST_DIV0;
            state <= S_ALU;
          end else state <= S_ALU;
        end
        S_ALU: begin
          if (alu_done) begin
            if (err == iee_pkg::ST_OK) begin
              vcount <= vcount - VW'(1);
              ocount <= ocount - OW'(1);
            end
            state <= (err != iee_pkg::ST_OK) ? (final_phase ? S_RES : S_FIN) : S_TOP;
          end
        end
        S_FIN: begin
          if (!last) state <= S_IDLE;
          else begin
            final_phase <= 1'b1;
            state       <= (err != iee_pkg::ST_OK) ? S_RES : S_TOP;
          end
        end
        S_RES: state <= S_RES2;
        S_RES2: begin
          if (!out_valid || !out_stall) begin
            out_valid       <= 1'b1;
            out_item.status <= (err == iee_pkg::ST_OK && vcount != VW'(1)) ?
                               iee_pkg::ST_MALFORMED : err;
            out_item.value  <= (err == iee_pkg::ST_OK && vcount == VW'(1)) ?
                               v_rdata : 32'd0;
            vcount      <= '0;
            ocount      <= '0;
            err         <= iee_pkg::ST_OK;
            final_phase <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  property p_vcount_bound;
    @(posedge clk) disable iff (rst) vcount <= VW'(VALUE_DEPTH);
  endproperty
  a_vcount_bound: assert property (p_vcount_bound) else $error("value count overflow");

  property p_ocount_bound;
    @(posedge clk) disable iff (rst) ocount <= OW'(OPERATOR_DEPTH);
  endproperty
  a_ocount_bound: assert property (p_ocount_bound) else $error("operator count overflow");

  property p_out_from_res;
    @(posedge clk) disable iff (rst) $rose(out_valid) |-> $past(state) == S_RES2;
  endproperty
  a_out_from_res: assert property (p_out_from_res) else $error("result outside final step");

  property p_reset_after_result;
    @(posedge clk) disable iff (rst) $rose(out_valid) |-> vcount == '0 && ocount == '0;
  endproperty
  a_reset_after_result: assert property (p_reset_after_result) else $error("stacks not cleared");

endmodule

@@ sv/iee_alu.sv @@
// Multi-cycle arithmetic unit: add, subtract, multiply
// and truncating signed divide (restoring, one quotient bit per cycle).
// Depends on iee_pkg.
module iee_alu (
  input  logic              clk,
  input  logic              rst,
  input  iee_pkg::alu_req_t req,
  output logic              done,
  output logic [31:0]       result
);

  logic        busy;
  logic [5:0]  count;
  logic [31:0] quo;
  logic [31:0] rem;
  logic [31:0] divisor;
  logic        neg;
  logic [32:0] trial;

  assign trial = {rem[31:0], quo[31]} - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        unique case (req.op)
          iee_pkg::OP_ADD: begin result <= req.a + req.b; done <= 1'b1; end
          iee_pkg::OP_SUB: begin result <= req.a - req.b; done <= 1'b1; end
          iee_pkg::OP_MUL: begin result <= req.a * req.b; done <= 1'b1; end
          default: begin
            busy    <= 1'b1;
            count   <= 6'd32;
            quo     <= req.a[31] ? 32'd0 - req.a : req.a;
            divisor <= req.b[31] ? 32'd0 - req.b : req.b;
            rem     <= 32'd0;
            neg     <= req.a[31] ^ req.b[31];
          end
        endcase
      end else if (busy) begin
        if (count == 6'd0) begin
          busy   <= 1'b0;
          done   <= 1'b1;
          result <= neg ? 32'd0 - quo : quo;
        end else begin
          count <= count - 6'd1;
          if (!trial[32]) begin
            rem <= trial[31:0];
            quo <= {quo[30:0], 1'b1};
          end else begin
            rem <= {rem[30:0], quo[31]};
            quo <= {quo[30:0], 1'b0};
          end
        end
      end
    end
  end

  property p_no_start_busy;
    @(posedge clk) disable iff (rst) busy |-> !req.start;
  endproperty
  a_no_start_busy: assert property (p_no_start_busy) else $error("alu restarted while busy");

  property p_done_pulse;
    @(posedge clk) disable iff (rst) done |=> !done || $past(req.start);
  endproperty
  a_done_pulse: assert property (p_done_pulse) else $error("alu done held");

  property p_count_range;
    @(posedge clk) disable iff (rst) busy |-> count <= 6'd32;
  endproperty
  a_count_range: assert property (p_count_range) else $error("divide count out of range");

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for infix_expression_evaluator_unit: feeds ASCII
// expressions one character per transaction and checks each result.
// Depends on iee_pkg and the evaluator RTL.
`timescale 1ns / 100ps

module testbench;

  localparam int VDEPTH = 16;
  localparam int ODEPTH = 16;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  iee_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  iee_pkg::out_item_t out_item;

  iee_pkg::in_item_t  pending_chars[$];
  iee_pkg::out_item_t expected_results[$];
  int         error_count = 0;
  bit         stimulus_done = 1'b0;
  int         cycle_count = 0;
  int         hold_off_start = 400;
  bit         quiet_stretch = 1'b0;

  // Evaluator state mirror.
  logic [31:0] vals[VDEPTH];
  int          nvals = 0;
  logic [2:0]  ops[ODEPTH];
  int          nops = 0;
  logic [1:0]  first_err = iee_pkg::ST_OK;

  infix_expression_evaluator_unit uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_item(in_item), .out_valid(out_valid), .out_stall(out_stall),
    .out_item(out_item)
  );

  always #10 clk = ~clk;

  function automatic int rank(input logic [2:0] op);
    if (op == iee_pkg::OP_MUL || op == iee_pkg::OP_DIV) return 2;
    if (op == iee_pkg::OP_ADD || op == iee_pkg::OP_SUB) return 1;
    return 0;
  endfunction

  function automatic logic [1:0] apply_top();
    logic [2:0]  op;
    logic [31:0] a, b, r, ma, mb, q;
    if (nops == 0 || nvals < 2) return iee_pkg::ST_MALFORMED;
    op = ops[nops-1];
    if (op == iee_pkg::OP_OPEN) return iee_pkg::ST_MALFORMED;
    b = vals[nvals-1];
    a = vals[nvals-2];
    case (op)
      iee_pkg::OP_ADD: r = a + b;
      iee_pkg::OP_SUB: r = a - b;
      iee_pkg::OP_MUL: r = a * b;
      default: begin
        if (b == 0) return iee_pkg::ST_DIV0;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q = ma / mb;
        r = (a[31] != b[31]) ? -q : q;
      end
    endcase
    nops--;
    nvals--;
    vals[nvals-1] = r;
    return iee_pkg::ST_OK;
  endfunction

  function automatic logic [1:0] take_char(input logic [7:0] c);
    logic [2:0] op;
    logic [1:0] s;
    if (c >= iee_pkg::CH_ZERO && c <= iee_pkg::CH_NINE) begin
      if (nvals >= VDEPTH) return iee_pkg::ST_OVERFLOW;
      vals[nvals] = 32'(c - iee_pkg::CH_ZERO);
      nvals++;
      return iee_pkg::ST_OK;
    end
    if (c == iee_pkg::CH_OPEN) begin
      if (nops >= ODEPTH) return iee_pkg::ST_OVERFLOW;
      ops[nops] = iee_pkg::OP_OPEN;
      nops++;
      return iee_pkg::ST_OK;
    end
    if (c == iee_pkg::CH_CLOSE) begin
      while (nops > 0 && ops[nops-1] != iee_pkg::OP_OPEN) begin
        s = apply_top();
        if (s != iee_pkg::ST_OK) return s;
      end
      if (nops == 0) return iee_pkg::ST_MALFORMED;
      nops--;
      return iee_pkg::ST_OK;
    end
    if (c == iee_pkg::CH_ADD) op = iee_pkg::OP_ADD;
    else if (c == iee_pkg::CH_SUB) op = iee_pkg::OP_SUB;
    else if (c == iee_pkg::CH_MUL) op = iee_pkg::OP_MUL;
    else if (c == iee_pkg::CH_DIV) op = iee_pkg::OP_DIV;
    else return iee_pkg::ST_MALFORMED;
    while (nops > 0 && rank(ops[nops-1]) >= rank(op)) begin
      s = apply_top();
      if (s != iee_pkg::ST_OK) return s;
    end
    if (nops >= ODEPTH) return iee_pkg::ST_OVERFLOW;
    ops[nops] = op;
    nops++;
    return iee_pkg::ST_OK;
  endfunction

  // Updates the mirror for one accepted character; queues a result on the last.
  task automatic evaluate_char(input iee_pkg::in_item_t it);
    iee_pkg::out_item_t res;
    if (first_err == iee_pkg::ST_OK) first_err = take_char(it.character);
    if (it.end_of_expression) begin
      while (first_err == iee_pkg::ST_OK && nops > 0) first_err = apply_top();
      if (first_err == iee_pkg::ST_OK && nvals != 1) first_err = iee_pkg::ST_MALFORMED;
      res.value = (first_err == iee_pkg::ST_OK) ? vals[0] : 32'd0;
      res.status = first_err;
      expected_results.push_back(res);
      nvals = 0;
      nops = 0;
      first_err = iee_pkg::ST_OK;
    end
  endtask

  task automatic add_expr(input string s);
    iee_pkg::in_item_t it;
    for (int i = 0; i < s.len(); i++) begin
      it.character = s[i];
      it.end_of_expression = (i == s.len() - 1);
      pending_chars.push_back(it);
    end
  endtask

  task automatic add_char(input logic [7:0] c, input logic last);
    iee_pkg::in_item_t it;
    it.character = c;
    it.end_of_expression = last;
    pending_chars.push_back(it);
  endtask

  // Well-formed expression with random operands, operators and nesting.
  task automatic add_random_expr();
    int terms, depth;
    logic [7:0] opch[4];
    opch = '{iee_pkg::CH_ADD, iee_pkg::CH_SUB, iee_pkg::CH_MUL, iee_pkg::CH_DIV};
    terms = $urandom_range(1, 7);
    depth = 0;
    for (int t = 0; t < terms; t++) begin
      if (depth < 4 && $urandom_range(0, 4) == 0) begin
        add_char(iee_pkg::CH_OPEN, 1'b0);
        depth++;
      end
      add_char(iee_pkg::CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
      if (depth > 0 && $urandom_range(0, 2) == 0) begin
        add_char(iee_pkg::CH_CLOSE, 1'b0);
        depth--;
      end
      if (t != terms - 1) add_char(opch[$urandom_range(0, 3)], 1'b0);
    end
    while (depth > 0) begin
      add_char(iee_pkg::CH_CLOSE, 1'b0);
      depth--;
    end
    pending_chars[$].end_of_expression = 1'b1;
  endtask

  initial begin
    int kind;
    add_expr("7");
    add_expr("9*9-0/3+4");
    add_expr("(1+2)*3");
    add_expr("8/0");
    add_expr("5)");
    add_expr("(5");
    add_expr("+");
    add_expr("1 2");
    add_expr("12");
    add_expr("11111111111111111");
    add_expr("((((((((((((((((("); // operator stack overflow
    add_expr("0-9/2");
    add_char(8'hFF, 1'b1);
    add_char(8'h00, 1'b1);
    while (pending_chars.size() < 1400) begin
      kind = $urandom_range(0, 19);
      if (kind < 16) add_random_expr();
      else if (kind == 16) add_char(8'($urandom), 1'b1);
      else if (kind == 17) begin
        repeat ($urandom_range(1, 18))
          add_char(iee_pkg::CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
        repeat ($urandom_range(0, 18)) add_char(iee_pkg::CH_MUL, 1'b0);
        add_char(iee_pkg::CH_NINE, 1'b1);
      end else begin
        repeat ($urandom_range(1, 8)) begin
          case ($urandom_range(0, 6))
            0: add_char(iee_pkg::CH_OPEN, 1'b0);
            1: add_char(iee_pkg::CH_CLOSE, 1'b0);
            2: add_char(iee_pkg::CH_DIV, 1'b0);
            3: add_char(iee_pkg::CH_SUB, 1'b0);
            4: add_char(iee_pkg::CH_ZERO, 1'b0);
            5: add_char(8'($urandom), 1'b0);
            default: add_char(iee_pkg::CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
          endcase
        end
        add_char(iee_pkg::CH_ZERO + 8'($urandom_range(0, 9)), 1'b1);
      end
    end
    // Each bit of the character field set once across two characters; the second sets the last flag.
    add_char(8'hAA, 1'b0);
    add_char(8'h55, 1'b1);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    quiet_stretch <= (cycle_count > 3000 && cycle_count < 6000);
  end

  // Driver.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) evaluate_char(in_item);
      if (!in_valid || !in_stall) begin
        if (pending_chars.size() > 0 && (quiet_stretch || $urandom_range(0, 99) >= 15)) begin
          in_item <= pending_chars.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
          if (pending_chars.size() == 0 && !(in_valid && !in_stall) && !in_valid)
            stimulus_done <= 1'b1;
        end
      end
    end
  end

  // Monitor and receiver stall, including one long hold-off.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result value=%0d status=%0d", $time,
                   out_item.value, out_item.status);
          error_count++;
        end else if (out_item !== expected_results[0]) begin
          $display("%0t: mismatch expected value=%0d status=%0d actual value=%0d status=%0d",
                   $time, expected_results[0].value, expected_results[0].status,
                   out_item.value, out_item.status);
          error_count++;
          void'(expected_results.pop_front());
        end else begin
          void'(expected_results.pop_front());
        end
      end
      if (cycle_count >= hold_off_start && cycle_count < hold_off_start + 1500)
        out_stall <= 1'b1;
      else
        out_stall <= !quiet_stretch && ($urandom_range(0, 99) < 15);
    end
  end

  initial begin
    wait (!rst);
    wait (stimulus_done && expected_results.size() == 0);
    repeat (200) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("testbench failed");
    $finish;
  end
endmodule

@@ infix_expression_evaluator_unit.f @@
sv/iee_pkg.sv
sv/iee_alu.sv
sv/infix_expression_evaluator_unit.sv
test/testbench.sv
